// ===== design/elevator_collective_controller_macros.svh =====
// Assertion macros used by the verification checker of the elevator controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ELEVATOR_COLLECTIVE_CONTROLLER_MACROS_SVH
`define ELEVATOR_COLLECTIVE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ecc_pkg.sv =====
// Package for the elevator collective controller: constants, codes and shared types.
// No dependencies; the top level, ecc_step and ecc_checker import it.
`default_nettype none

package ecc_pkg;

    localparam int NUM_FLOORS  = 6;
    localparam int NUM_BUTTONS = 5;
    localparam int FLOOR_W     = 3;

    localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(NUM_FLOORS - 1);

    localparam logic [1:0] DIR_UP      = 2'd0;
    localparam logic [1:0] DIR_NEUTRAL = 2'd1;
    localparam logic [1:0] DIR_DOWN    = 2'd2;

    localparam logic [2:0] DOOR_MAX  = 3'd5;
    localparam logic [6:0] DEB_SAT   = 7'd127;
    localparam logic [3:0] DELAY_SAT = 4'd15;

    localparam int BTN_OPEN_BIT  = 6;
    localparam int BTN_CLOSE_BIT = 7;

    localparam logic [2:0] CFG_STEPS_PER_FLOOR  = 3'd0;
    localparam logic [2:0] CFG_STEPS_PER_TICK   = 3'd1;
    localparam logic [2:0] CFG_DOOR_HOLD_TICKS  = 3'd2;
    localparam logic [2:0] CFG_DOOR_STEP_DELAY  = 3'd3;
    localparam logic [2:0] CFG_DEBOUNCE_WAIT    = 3'd4;
    localparam logic [2:0] CFG_FORCE_OPEN_POLLS = 3'd5;

    localparam logic [9:0] RST_STEPS_PER_FLOOR  = 10'd660;
    localparam logic [5:0] RST_STEPS_PER_TICK   = 6'd5;
    localparam logic [7:0] RST_DOOR_HOLD_TICKS  = 8'd15;
    localparam logic [3:0] RST_DOOR_STEP_DELAY  = 4'd4;
    localparam logic [6:0] RST_DEBOUNCE_WAIT    = 7'd15;
    localparam logic [7:0] RST_FORCE_OPEN_POLLS = 8'd20;

    localparam logic [FLOOR_W-1:0] RST_FLOOR = FLOOR_W'(1);

    typedef struct packed {
        logic [9:0] steps_per_floor;
        logic [5:0] steps_per_tick;
        logic [7:0] door_hold_ticks;
        logic [3:0] door_step_delay;
        logic [6:0] debounce_wait;
        logic [7:0] force_open_polls;
    } cfg_t;

    typedef struct packed {
        logic [NUM_FLOORS-1:0]       requests;
        logic [FLOOR_W-1:0]          floor_now;
        logic [1:0]                  travel_dir;
        logic                        car_moving;
        logic                        arrival_opening;
        logic                        door_fully_open;
        logic [2:0]                  door_position;
        logic [7:0]                  hold_left;
        logic                        force_open_flag;
        logic [7:0]                  force_open_timer;
        logic [9:0]                  step_count;
        logic [3:0]                  door_delay_count;
        logic [NUM_BUTTONS-1:0][6:0] debounce_counts;
    } state_t;

    typedef struct packed {
        logic [2:0] current_floor;
        logic [5:0] request_mask;
        logic [1:0] direction;
        logic       moving;
        logic [2:0] door_level;
        logic       door_open;
        logic       chime;
        logic [5:0] motor_steps;
        logic       motor_up;
    } result_t;

endpackage

`default_nettype wire

// ===== design/ecc_in_if.sv =====
// Input channel of the elevator controller: one word is a tick or a button poll.
// Depends on nothing.
`default_nettype none

interface ecc_in_if;
    logic       valid;
    logic       ready;
    logic [0:0] cmd;
    logic [7:0] buttons;

    modport source (output valid, output cmd, output buttons, input ready);
    modport sink (input valid, input cmd, input buttons, output ready);
endinterface

`default_nettype wire

// ===== design/ecc_out_if.sv =====
// Result channel of the elevator controller: one word of car and door status per item.
// Depends on nothing.
`default_nettype none

interface ecc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] current_floor;
    logic [5:0] request_mask;
    logic [1:0] direction;
    logic [0:0] moving;
    logic [2:0] door_level;
    logic [0:0] door_open;
    logic [0:0] chime;
    logic [5:0] motor_steps;
    logic [0:0] motor_up;

    modport source (
        output valid, input ready,
        output current_floor, output request_mask, output direction, output moving,
        output door_level, output door_open, output chime, output motor_steps,
        output motor_up
    );
    modport sink (
        input valid, output ready,
        input current_floor, input request_mask, input direction, input moving,
        input door_level, input door_open, input chime, input motor_steps,
        input motor_up
    );
endinterface

`default_nettype wire

// ===== design/elevator_collective_controller.sv =====
// Top level of the single-car elevator collective controller.
// Uses ecc_pkg, the channel interfaces ecc_in_if and ecc_out_if, and ecc_step.
//
// The block takes one word per clock cycle while the result channel is not stalled,
// and returns one result word per input word. An accepted word lands in an input
// register; when the result register is free, a single pass of next-state logic
// (ecc_step) updates the car, door, request and debounce state and loads the result
// register. That one pass is what sets the rate of one word per cycle. The result
// register holds one word; while it waits on a stalled consumer the input register
// still takes one more word. Configuration registers come out of reset at their
// default values and are meant to be written only while the block is idle.
`default_nettype none

module elevator_collective_controller
    import ecc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ecc_in_if.sink     item,
    ecc_out_if.source  result,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_wdata
);

    cfg_t       cfg_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    res_next;
    result_t    res_reg;
    logic       in_valid_reg;
    logic       cmd_reg;
    logic [7:0] buttons_reg;
    logic       out_valid_reg;
    logic       step_fire;
    logic       item_fire;

    assign step_fire = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || step_fire;
    assign item_fire = item.valid && item.ready;

    ecc_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .cmd     (cmd_reg),
        .buttons (buttons_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_floor  <= RST_STEPS_PER_FLOOR;
            cfg_reg.steps_per_tick   <= RST_STEPS_PER_TICK;
            cfg_reg.door_hold_ticks  <= RST_DOOR_HOLD_TICKS;
            cfg_reg.door_step_delay  <= RST_DOOR_STEP_DELAY;
            cfg_reg.debounce_wait    <= RST_DEBOUNCE_WAIT;
            cfg_reg.force_open_polls <= RST_FORCE_OPEN_POLLS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEPS_PER_FLOOR:  cfg_reg.steps_per_floor  <= cfg_wdata;
                CFG_STEPS_PER_TICK:   cfg_reg.steps_per_tick   <= cfg_wdata[5:0];
                CFG_DOOR_HOLD_TICKS:  cfg_reg.door_hold_ticks  <= cfg_wdata[7:0];
                CFG_DOOR_STEP_DELAY:  cfg_reg.door_step_delay  <= cfg_wdata[3:0];
                CFG_DEBOUNCE_WAIT:    cfg_reg.debounce_wait    <= cfg_wdata[6:0];
                CFG_FORCE_OPEN_POLLS: cfg_reg.force_open_polls <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.requests         <= '0;
            state_reg.floor_now        <= RST_FLOOR;
            state_reg.travel_dir       <= DIR_NEUTRAL;
            state_reg.car_moving       <= 1'b0;
            state_reg.arrival_opening  <= 1'b0;
            state_reg.door_fully_open  <= 1'b0;
            state_reg.door_position    <= '0;
            state_reg.hold_left        <= '0;
            state_reg.force_open_flag  <= 1'b0;
            state_reg.force_open_timer <= '0;
            state_reg.step_count       <= '0;
            state_reg.door_delay_count <= '0;
            state_reg.debounce_counts  <= {NUM_BUTTONS{RST_DEBOUNCE_WAIT}};
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
        end
        else
        begin
            if (step_fire)
                state_reg <= state_next;
            if (item_fire)
                in_valid_reg <= 1'b1;
            else if (step_fire)
                in_valid_reg <= 1'b0;
            if (step_fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            cmd_reg     <= item.cmd[0];
            buttons_reg <= item.buttons;
        end
        if (step_fire)
            res_reg <= res_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.current_floor = res_reg.current_floor;
    assign result.request_mask  = res_reg.request_mask;
    assign result.direction     = res_reg.direction;
    assign result.moving        = res_reg.moving;
    assign result.door_level    = res_reg.door_level;
    assign result.door_open     = res_reg.door_open;
    assign result.chime         = res_reg.chime;
    assign result.motor_steps   = res_reg.motor_steps;
    assign result.motor_up      = res_reg.motor_up;

endmodule

`default_nettype wire

// ===== design/ecc_step.sv =====
// Next-state and result logic of the elevator controller for one tick or button poll.
// Purely combinational; uses the types and constants of ecc_pkg.
`default_nettype none

module ecc_step
    import ecc_pkg::*;
(
    input  state_t     st,
    input  cfg_t       cfg,
    input  logic       cmd,
    input  logic [7:0] buttons,
    output state_t     st_next,
    output result_t    res
);

    function automatic logic req_bit(input logic [NUM_FLOORS-1:0] req,
                                     input logic [FLOOR_W-1:0] f);
        logic [NUM_FLOORS-1:0] sh;
        sh = req >> f;
        return ({1'b0, f} < (FLOOR_W + 1)'(NUM_FLOORS)) && sh[0];
    endfunction

    function automatic logic calls_ahead(input logic [NUM_FLOORS-1:0] req,
                                         input logic [FLOOR_W-1:0] floor_now,
                                         input logic [1:0] dir);
        logic hit;
        logic [FLOOR_W-1:0] fi;
        hit = 1'b0;
        for (int f = 0; f < NUM_FLOORS; f++)
        begin
            fi = FLOOR_W'(f);
            if (dir == DIR_UP && fi > floor_now && req[f])
                hit = 1'b1;
            if (dir == DIR_DOWN && f >= 1 && fi < floor_now && req[f])
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic state_t start_travel(input state_t s_in);
        state_t s;
        logic [1:0] back;
        s = s_in;
        back = (s.travel_dir == DIR_UP) ? DIR_DOWN : DIR_UP;
        if (s.travel_dir == DIR_UP || s.travel_dir == DIR_DOWN)
        begin
            if (!calls_ahead(s.requests, s.floor_now, s.travel_dir))
            begin
                if (calls_ahead(s.requests, s.floor_now, back))
                begin
                    s.travel_dir = back;
                    s.car_moving = 1'b1;
                end
                else
                begin
                    s.travel_dir = DIR_NEUTRAL;
                end
            end
            else
            begin
                s.car_moving = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic state_t press_floor(input state_t s_in, input logic [FLOOR_W-1:0] f);
        state_t s;
        s = s_in;
        if (f != s.floor_now)
            s.requests = s.requests ^ (NUM_FLOORS'(1) << f);
        if (req_bit(s.requests, f) && s.travel_dir == DIR_NEUTRAL)
        begin
            if (f > s.floor_now)
                s.travel_dir = DIR_UP;
            else if (f < s.floor_now)
                s.travel_dir = DIR_DOWN;
            s = start_travel(s);
        end
        return s;
    endfunction

    state_t     s;
    logic       chime;
    logic [5:0] msteps;
    logic       mup;
    logic [10:0] step_sum;
    logic [9:0] step_new;
    logic       at_end;
    logic       door_ready;
    logic [3:0] pos_inc;

    always_comb
    begin
        s = st;
        chime = 1'b0;
        msteps = '0;
        mup = 1'b0;
        step_sum = '0;
        step_new = '0;
        at_end = 1'b0;
        door_ready = 1'b0;
        pos_inc = '0;
        if (cmd)
        begin
            if (s.force_open_timer < cfg.force_open_polls)
            begin
                s.force_open_timer = s.force_open_timer + 8'd1;
            end
            else
            begin
                s.force_open_flag = 1'b0;
                s.force_open_timer = '0;
            end
            if ((buttons[BTN_OPEN_BIT] || buttons[BTN_CLOSE_BIT]) && !s.car_moving)
            begin
                if (buttons[BTN_OPEN_BIT])
                begin
                    s.force_open_flag = 1'b1;
                    s.force_open_timer = '0;
                end
                else
                begin
                    s.hold_left = '0;
                end
            end
            for (int k = 0; k < NUM_BUTTONS; k++)
            begin
                if (st.debounce_counts[k] > cfg.debounce_wait && buttons[k] &&
                    k + 1 < NUM_FLOORS)
                begin
                    s = press_floor(s, FLOOR_W'(k + 1));
                    s.debounce_counts[k] = '0;
                end
            end
            for (int k = 0; k < NUM_BUTTONS; k++)
            begin
                if (s.debounce_counts[k] <= cfg.debounce_wait &&
                    s.debounce_counts[k] < DEB_SAT)
                    s.debounce_counts[k] = s.debounce_counts[k] + 7'd1;
            end
        end
        else if (s.car_moving)
        begin
            if (s.travel_dir == DIR_UP || s.travel_dir == DIR_DOWN)
            begin
                msteps = cfg.steps_per_tick;
                mup = (s.travel_dir == DIR_UP);
            end
            step_sum = {1'b0, s.step_count} + 11'(cfg.steps_per_tick);
            if (step_sum > {1'b0, cfg.steps_per_floor})
                step_new = cfg.steps_per_floor;
            else
                step_new = step_sum[9:0];
            if (step_new >= cfg.steps_per_floor)
            begin
                if (s.travel_dir == DIR_UP)
                begin
                    if (s.floor_now < TOP_FLOOR)
                        s.floor_now = s.floor_now + FLOOR_W'(1);
                    at_end = (s.floor_now >= TOP_FLOOR);
                end
                else if (s.travel_dir == DIR_DOWN)
                begin
                    if (s.floor_now != '0)
                        s.floor_now = s.floor_now - FLOOR_W'(1);
                    at_end = (s.floor_now == '0);
                end
                if ((s.requests == '0 && s.travel_dir != DIR_NEUTRAL) ||
                    req_bit(s.requests, s.floor_now) || at_end)
                begin
                    s.requests = s.requests & ~(NUM_FLOORS'(1) << s.floor_now);
                    s.car_moving = 1'b0;
                    s.arrival_opening = 1'b1;
                    chime = 1'b1;
                end
                step_new = '0;
            end
            s.step_count = step_new;
        end
        else
        begin
            door_ready = s.door_delay_count > cfg.door_step_delay;
            if (door_ready && s.arrival_opening)
            begin
                pos_inc = {1'b0, s.door_position} + 4'd1;
                if (pos_inc > {1'b0, DOOR_MAX})
                begin
                    s.arrival_opening = 1'b0;
                    s.door_position = DOOR_MAX;
                    s.door_fully_open = 1'b1;
                    s.hold_left = cfg.door_hold_ticks;
                end
                else
                begin
                    s.door_position = pos_inc[2:0];
                end
                s.door_delay_count = '0;
            end
            else if (door_ready && (s.force_open_flag || s.hold_left != '0))
            begin
                if (s.door_position < DOOR_MAX)
                    s.door_position = s.door_position + 3'd1;
                if (s.hold_left != '0)
                    s.hold_left = s.hold_left - 8'd1;
                s.door_delay_count = '0;
            end
            else if (door_ready && s.hold_left == '0)
            begin
                if (s.door_position != '0)
                    s.door_position = s.door_position - 3'd1;
                if (s.door_position == '0)
                begin
                    s.door_fully_open = 1'b0;
                    s = start_travel(s);
                end
                s.door_delay_count = '0;
            end
            if (s.door_delay_count <= cfg.door_step_delay && s.door_delay_count < DELAY_SAT)
                s.door_delay_count = s.door_delay_count + 4'd1;
        end
    end

    assign st_next = s;

    assign res.current_floor = s.floor_now;
    assign res.request_mask  = s.requests;
    assign res.direction     = s.travel_dir;
    assign res.moving        = s.car_moving;
    assign res.door_level    = s.door_position;
    assign res.door_open     = s.door_fully_open;
    assign res.chime         = chime;
    assign res.motor_steps   = msteps;
    assign res.motor_up      = mup;

endmodule

`default_nettype wire

// ===== design/ecc_checker.sv =====
// Port-level checker for the elevator controller, bound to the top level.
// Uses ecc_pkg and the assertion macros of elevator_collective_controller_macros.svh.
`default_nettype none
`include "elevator_collective_controller_macros.svh"

module ecc_checker
    import ecc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] current_floor,
    input logic [5:0] request_mask,
    input logic [1:0] direction,
    input logic       moving,
    input logic [2:0] door_level,
    input logic       door_open,
    input logic       chime,
    input logic [5:0] motor_steps,
    input logic       motor_up
);

    logic [23:0] res_word;
    logic        stalled;
    logic        car_sane;

    assign res_word = {current_floor, request_mask, direction, moving, door_level,
                       door_open, chime, motor_steps, motor_up};
    assign stalled  = res_valid && !res_ready;
    assign car_sane = current_floor <= TOP_FLOOR && !request_mask[0] &&
                      (!motor_up || direction == DIR_UP);

    `ECC_ASSERT_NEXT(a_valid_holds, stalled, res_valid, "result word dropped while stalled")
    `ECC_ASSERT_NEXT(a_word_holds, stalled, $stable(res_word), "stalled result word changed")
    `ECC_ASSERT_SAME(a_chime_stops, res_valid && chime, !moving, "chime while the car moves")
    `ECC_ASSERT_SAME(a_car_sane, res_valid, car_sane, "floor, request or motor out of place")

endmodule

bind elevator_collective_controller ecc_checker u_ecc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .current_floor (result.current_floor),
    .request_mask  (result.request_mask),
    .direction     (result.direction),
    .moving        (result.moving[0]),
    .door_level    (result.door_level),
    .door_open     (result.door_open[0]),
    .chime         (result.chime[0]),
    .motor_steps   (result.motor_steps),
    .motor_up      (result.motor_up[0])
);

`default_nettype wire
